[rtl/subarray_region_address_defines.svh]
// Assertion macros for the subarray region address RTL.
`ifndef SUBARRAY_REGION_ADDRESS_DEFINES_SVH
`define SUBARRAY_REGION_ADDRESS_DEFINES_SVH

`ifndef SYNTHESIS
// Flag any cycle at which expr holds.
`define SRA_ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("sra: forbidden condition seen");
// Require b in the cycle after a.
`define SRA_ASSERT_NEXT(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("sra: expected follow-up missing");
`else
`define SRA_ASSERT_NEVER(lbl, clk, rst_n, expr)
`define SRA_ASSERT_NEXT(lbl, clk, rst_n, a, b)
`endif

`endif

[rtl/sra_pkg.sv]
// Types, constants and helper functions of the subarray region address generator.
package sra_pkg;

    localparam int MAX_DIMS   = 4;
    localparam int DIM_BITS   = 16;
    localparam int IDX_W      = 48;
    localparam int OFF_W      = 64;
    localparam int RUN_W      = 32;
    localparam int EXT_W      = 16;
    localparam int DCNT_W     = 3;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int DIV_STEP   = 4;
    localparam int DIV_STAGES = (IDX_W + DIV_STEP - 1) / DIV_STEP;
    localparam int N_W        = $clog2(MAX_DIMS + 1);
    localparam int DIM_IDX_W  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DIM_COUNT    = 3'd0,
        REG_COLUMN_MAJOR = 3'd1,
        REG_ELEM_EXTENT  = 3'd2,
        REG_FULL_SIZES   = 3'd3,
        REG_SUB_SIZES    = 3'd4,
        REG_START_OFFS   = 3'd5
    } t_reg_idx;

    // Every size field set to one.
    function automatic logic [CFG_DATA_W-1:0] sizes_reset();
        logic [CFG_DATA_W-1:0] v;
        v = '0;
        for (int d = 0; d < MAX_DIMS; d++) begin
            if (d * DIM_BITS < CFG_DATA_W) begin
                v[d * DIM_BITS] = 1'b1;
            end
        end
        return v;
    endfunction

    localparam logic [CFG_DATA_W-1:0] SIZES_RESET = sizes_reset();

    typedef struct packed {
        logic [N_W-1:0]        n;
        logic                  col;
        logic [EXT_W-1:0]      ext;
        logic [CFG_DATA_W-1:0] full;
        logic [CFG_DATA_W-1:0] sub;
        logic [CFG_DATA_W-1:0] start;
    } t_cfg;

    typedef struct packed {
        logic [IDX_W-1:0]                   q;
        logic [MAX_DIMS-1:0][DIM_BITS-1:0]  dig;
        logic                               zero;
    } t_item;

    typedef struct packed {
        logic                               inr;
        logic [MAX_DIMS-1:0][DIM_BITS-1:0]  dig;
        logic [OFF_W-1:0]                   off;
    } t_hitem;

    typedef struct packed {
        logic [OFF_W-1:0] off;
        logic [RUN_W-1:0] run;
        logic             inr;
    } t_res;

    function automatic logic [DIM_BITS-1:0] dim_field(logic [CFG_DATA_W-1:0] p,
                                                      logic [DIM_IDX_W-1:0] d);
        int sh;
        sh = int'(d) * DIM_BITS;
        if (sh >= CFG_DATA_W) begin
            return '0;
        end
        return DIM_BITS'(p >> sh);
    endfunction

    // Dimension split by division slot k: fastest-varying non-contiguous first.
    function automatic logic [DIM_IDX_W-1:0] div_dim(logic [N_W-1:0] n, logic col,
                                                     logic [DIM_IDX_W-1:0] k);
        int v;
        v = col ? int'(k) : (int'(n) - 1 - int'(k));
        return DIM_IDX_W'(v);
    endfunction

    // Dimension folded by Horner step k: slowest first, contiguous last.
    function automatic logic [DIM_IDX_W-1:0] horner_dim(logic [N_W-1:0] n, logic col,
                                                        logic [DIM_IDX_W-1:0] k);
        int v;
        v = col ? (int'(n) - 1 - int'(k)) : int'(k);
        return DIM_IDX_W'(v);
    endfunction

endpackage

[rtl/sra_div_slot.sv]
// One mixed-radix split: pipelined restoring divide of the index by a sub size.
module sra_div_slot (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic [sra_pkg::DIM_IDX_W-1:0] i_slot,
    input  sra_pkg::t_cfg              i_cfg,
    input  logic                       i_v,
    input  sra_pkg::t_item             i_item,
    output logic                       o_v,
    output sra_pkg::t_item             o_item
);

    localparam int LAST = sra_pkg::DIV_STAGES - 1;

    logic                                 act;
    logic [sra_pkg::DIM_IDX_W-1:0]        dsel;
    logic [sra_pkg::DIM_BITS-1:0]         dvs;

    logic                                 r_v   [sra_pkg::DIV_STAGES];
    sra_pkg::t_item                       r_it  [sra_pkg::DIV_STAGES];
    logic [sra_pkg::IDX_W-1:0]            r_w   [sra_pkg::DIV_STAGES];
    logic [sra_pkg::DIM_BITS-1:0]         r_rem [sra_pkg::DIV_STAGES];

    always_comb begin
        act  = int'(i_slot) < int'(i_cfg.n);
        dsel = sra_pkg::div_dim(i_cfg.n, i_cfg.col, i_slot);
        dvs  = sra_pkg::dim_field(i_cfg.sub, dsel);
    end

    for (genvar s = 0; s < sra_pkg::DIV_STAGES; s++) begin : g_st
        logic                         v_in;
        sra_pkg::t_item               it_in;
        logic [sra_pkg::IDX_W-1:0]    w_in;
        logic [sra_pkg::IDX_W-1:0]    n_w;
        logic [sra_pkg::DIM_BITS-1:0] rem_in;
        logic [sra_pkg::DIM_BITS-1:0] n_rem;
        logic [sra_pkg::DIM_BITS:0]   t;

        if (s == 0) begin : g_first
            assign v_in   = i_v;
            assign it_in  = i_item;
            assign w_in   = i_item.q;
            assign rem_in = '0;
        end else begin : g_next
            assign v_in   = r_v[s-1];
            assign it_in  = r_it[s-1];
            assign w_in   = r_w[s-1];
            assign rem_in = r_rem[s-1];
        end

        // Shift in a few dividend bits, subtract where the divisor fits.
        always_comb begin
            n_w   = w_in;
            n_rem = rem_in;
            t     = '0;
            for (int b = 0; b < sra_pkg::DIV_STEP; b++) begin
                if (s * sra_pkg::DIV_STEP + b < sra_pkg::IDX_W) begin
                    t   = {n_rem, n_w[sra_pkg::IDX_W-1]};
                    n_w = {n_w[sra_pkg::IDX_W-2:0], 1'b0};
                    if (t >= {1'b0, dvs}) begin
                        t      = t - {1'b0, dvs};
                        n_w[0] = 1'b1;
                    end
                    n_rem = t[sra_pkg::DIM_BITS-1:0];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else if (i_en) begin
                r_v[s] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_it[s]  <= it_in;
                r_w[s]   <= n_w;
                r_rem[s] <= n_rem;
            end
        end
    end

    // Commit the split; a zero divisor passes the quotient and empties the range.
    always_comb begin
        o_v    = r_v[LAST];
        o_item = r_it[LAST];
        if (act) begin
            if (dvs != '0) begin
                o_item.q         = r_w[LAST];
                o_item.dig[dsel] = r_rem[LAST];
            end else begin
                o_item.zero = 1'b1;
            end
        end
    end

endmodule

[rtl/sra_horner.sv]
// Horner accumulation of the element offset, then scaling by the element extent.
module sra_horner (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  sra_pkg::t_cfg  i_cfg,
    input  logic           i_v,
    input  sra_pkg::t_item i_item,
    output logic           o_v,
    output sra_pkg::t_res  o_res
);

    logic            r_v [sra_pkg::MAX_DIMS];
    sra_pkg::t_hitem r_h [sra_pkg::MAX_DIMS];
    logic            r_res_v;
    sra_pkg::t_res   r_res;
    sra_pkg::t_hitem entry;
    sra_pkg::t_res   n_res;

    always_comb begin
        entry.inr = !i_item.zero && (i_item.q == '0);
        entry.dig = i_item.dig;
        entry.off = '0;
    end

    for (genvar k = 0; k < sra_pkg::MAX_DIMS; k++) begin : g_st
        logic                          v_in;
        sra_pkg::t_hitem               h_in;
        sra_pkg::t_hitem               n_h;
        logic [sra_pkg::DIM_IDX_W-1:0] d;

        if (k == 0) begin : g_first
            assign v_in = i_v;
            assign h_in = entry;
        end else begin : g_next
            assign v_in = r_v[k-1];
            assign h_in = r_h[k-1];
        end

        always_comb begin
            d   = sra_pkg::horner_dim(i_cfg.n, i_cfg.col, sra_pkg::DIM_IDX_W'(k));
            n_h = h_in;
            if (k < int'(i_cfg.n)) begin
                n_h.off = sra_pkg::OFF_W'(sra_pkg::dim_field(i_cfg.start, d))
                        + sra_pkg::OFF_W'(h_in.dig[d])
                        + sra_pkg::OFF_W'(
                              sra_pkg::OFF_W'(sra_pkg::dim_field(i_cfg.full, d)) * h_in.off);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_h[k] <= n_h;
            end
        end
    end

    always_comb begin
        logic [sra_pkg::DIM_BITS-1:0] contig;
        contig    = sra_pkg::dim_field(i_cfg.sub, i_cfg.col ? '0 :
                        sra_pkg::DIM_IDX_W'(int'(i_cfg.n) - 1));
        n_res.off = sra_pkg::OFF_W'(r_h[sra_pkg::MAX_DIMS-1].off *
                        sra_pkg::OFF_W'(i_cfg.ext));
        n_res.run = sra_pkg::RUN_W'(sra_pkg::RUN_W'(contig) * sra_pkg::RUN_W'(i_cfg.ext));
        n_res.inr = r_h[sra_pkg::MAX_DIMS-1].inr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_v <= 1'b0;
        end else if (i_en) begin
            r_res_v <= r_v[sra_pkg::MAX_DIMS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res <= n_res;
        end
    end

    assign o_v   = r_res_v;
    assign o_res = r_res;

endmodule

[rtl/subarray_region_address.sv]
// Top level of the subarray region address generator.
//
//  channel   direction  handshake            payload
//  -------   ---------  -------------------  ------------------------------------------
//  region    in         i_valid / o_stall    i_region_index
//  address   out        o_valid / i_stall    o_byte_offset, o_run_length,
//                                            o_index_in_range
//  config    in         i_cfg_we             i_cfg_index, i_cfg_data
//
// One transaction per cycle sustained while i_stall is low. Each split is a 12-stage
// restoring divider taking four quotient bits a stage, then come one Horner multiply-add
// per dimension, one extent multiply and the output register.
// Reset is synchronous, active low; it clears valid bits and loads register defaults.
// The pipeline advances as one; a skid register behind the output register keeps
// input flowing while a result waits, and o_stall rises only once the skid is full.
`include "subarray_region_address_defines.svh"

module subarray_region_address (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [sra_pkg::IDX_W-1:0]         i_region_index,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [sra_pkg::OFF_W-1:0]         o_byte_offset,
    output logic [sra_pkg::RUN_W-1:0]         o_run_length,
    output logic                              o_index_in_range,
    input  logic                              i_cfg_we,
    input  logic [sra_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [sra_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    // Configuration registers.
    logic [sra_pkg::DCNT_W-1:0]     r_dim_count;
    logic                           r_column_major;
    logic [sra_pkg::EXT_W-1:0]      r_elem_extent;
    logic [sra_pkg::CFG_DATA_W-1:0] r_full_sizes;
    logic [sra_pkg::CFG_DATA_W-1:0] r_sub_sizes;
    logic [sra_pkg::CFG_DATA_W-1:0] r_start_offsets;
    sra_pkg::t_cfg                  cfg;

    // Pipeline plumbing.
    logic                           en;
    logic                           c_v  [sra_pkg::MAX_DIMS];
    sra_pkg::t_item                 c_it [sra_pkg::MAX_DIMS];
    logic                           h_v;
    sra_pkg::t_res                  h_res;
    logic                           push;
    logic                           out_free;

    // Output register and skid.
    logic                           r_ov;
    sra_pkg::t_res                  r_o;
    logic                           r_sv;
    sra_pkg::t_res                  r_s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim_count     <= sra_pkg::DCNT_W'(1);
            r_column_major  <= 1'b0;
            r_elem_extent   <= sra_pkg::EXT_W'(1);
            r_full_sizes    <= sra_pkg::SIZES_RESET;
            r_sub_sizes     <= sra_pkg::SIZES_RESET;
            r_start_offsets <= '0;
        end else if (i_cfg_we) begin
            unique case (sra_pkg::t_reg_idx'(i_cfg_index))
                sra_pkg::REG_DIM_COUNT:    r_dim_count     <= i_cfg_data[sra_pkg::DCNT_W-1:0];
                sra_pkg::REG_COLUMN_MAJOR: r_column_major  <= i_cfg_data[0];
                sra_pkg::REG_ELEM_EXTENT:  r_elem_extent   <= i_cfg_data[sra_pkg::EXT_W-1:0];
                sra_pkg::REG_FULL_SIZES:   r_full_sizes    <= i_cfg_data;
                sra_pkg::REG_SUB_SIZES:    r_sub_sizes     <= i_cfg_data;
                sra_pkg::REG_START_OFFS:   r_start_offsets <= i_cfg_data;
                default: ;  // drop writes to unknown indexes
            endcase
        end
    end

    // Clamp the dimension count: zero acts as one, excess as MAX_DIMS.
    always_comb begin
        if (r_dim_count == '0) begin
            cfg.n = sra_pkg::N_W'(1);
        end else if (int'(r_dim_count) > sra_pkg::MAX_DIMS) begin
            cfg.n = sra_pkg::N_W'(sra_pkg::MAX_DIMS);
        end else begin
            cfg.n = sra_pkg::N_W'(r_dim_count);
        end
        cfg.col   = r_column_major;
        cfg.ext   = r_elem_extent;
        cfg.full  = r_full_sizes;
        cfg.sub   = r_sub_sizes;
        cfg.start = r_start_offsets;
    end

    // Advance everything while the skid is free; hold when it is occupied.
    assign en      = !r_sv;
    assign o_stall = r_sv;

    always_comb begin
        c_v[0]       = i_valid;
        c_it[0].q    = i_region_index;
        c_it[0].dig  = '0;
        c_it[0].zero = 1'b0;
    end

    // One divider slot per non-contiguous dimension.
    for (genvar k = 1; k < sra_pkg::MAX_DIMS; k++) begin : g_slot
        sra_div_slot u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_slot  (sra_pkg::DIM_IDX_W'(k)),
            .i_cfg   (cfg),
            .i_v     (c_v[k-1]),
            .i_item  (c_it[k-1]),
            .o_v     (c_v[k]),
            .o_item  (c_it[k])
        );
    end

    sra_horner u_horner (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_cfg   (cfg),
        .i_v     (c_v[sra_pkg::MAX_DIMS-1]),
        .i_item  (c_it[sra_pkg::MAX_DIMS-1]),
        .o_v     (h_v),
        .o_res   (h_res)
    );

    assign push     = h_v && en;
    assign out_free = !r_ov || !i_stall;

    // Output register refills from the skid first, then from the pipeline tail.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (out_free) begin
            if (r_sv) begin
                r_ov <= 1'b1;
                r_sv <= 1'b0;
            end else begin
                r_ov <= push;
            end
        end else if (push) begin
            r_sv <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_o <= r_sv ? r_s : h_res;
        end
        if (push) begin
            r_s <= h_res;
        end
    end

    assign o_valid          = r_ov;
    assign o_byte_offset    = r_o.off;
    assign o_run_length     = r_o.run;
    assign o_index_in_range = r_o.inr;

    // The skid only fills behind a held result.
    `SRA_ASSERT_NEVER(a_skid_behind_out, i_clk, i_rst_n, r_sv && !r_ov)
    // A held result with a new arrival parks the arrival in the skid.
    `SRA_ASSERT_NEXT(a_park_in_skid, i_clk, i_rst_n, push && !out_free, r_sv && r_ov)
    // Draining the skid keeps the output valid.
    `SRA_ASSERT_NEXT(a_skid_drains, i_clk, i_rst_n, r_sv && out_free, r_ov && !r_sv)

endmodule

[test/sra_checker.sv]
// Address checker: predicts each region address and compares what the block returns.
`timescale 1ns / 100ps

module sra_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  logic                              i_stall_in,
    input  logic [sra_pkg::IDX_W-1:0]         i_region_index,
    input  logic                              i_out_valid,
    input  logic                              i_out_stall,
    input  logic [sra_pkg::OFF_W-1:0]         i_byte_offset,
    input  logic [sra_pkg::RUN_W-1:0]         i_run_length,
    input  logic                              i_index_in_range,
    input  logic                              i_cfg_we,
    input  logic [sra_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [sra_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output int                                o_errors,
    output int                                o_pending
);
    import sra_pkg::*;

    typedef struct packed {
        logic [OFF_W-1:0] byte_offset;
        logic [RUN_W-1:0] run_length;
        logic             in_range;
    } t_address;

    t_address              address_q[$];
    logic [DCNT_W-1:0]     dims_reg;
    logic                  col_major_reg;
    logic [EXT_W-1:0]      extent_reg;
    logic [CFG_DATA_W-1:0] full_reg;
    logic [CFG_DATA_W-1:0] sub_reg;
    logic [CFG_DATA_W-1:0] start_reg;

    function automatic logic [63:0] size_of(logic [63:0] packed_sizes, int d);
        return 64'(packed_sizes[d*DIM_BITS +: DIM_BITS]);
    endfunction

    function automatic t_address region_address(logic [IDX_W-1:0] region);
        t_address    a;
        int          n;
        int          d;
        logic [63:0] quot;
        logic [63:0] s;
        logic [63:0] regions;
        logic [63:0] off;
        logic [63:0] digit[MAX_DIMS];
        n = int'(dims_reg);
        if (n < 1) n = 1;
        if (n > MAX_DIMS) n = MAX_DIMS;
        quot = 64'(region);
        regions = 64'd1;
        off = '0;
        for (int k = 0; k < MAX_DIMS; k++) digit[k] = '0;
        // split the index, fastest-varying non-contiguous dimension first
        for (int k = 1; k < n; k++) begin
            d = col_major_reg ? k : (n - 1 - k);
            s = size_of(sub_reg, d);
            regions = regions * s;
            if (s != 0) begin
                digit[d] = quot % s;
                quot = quot / s;
            end
        end
        // fold from the slowest dimension down to the contiguous one
        for (int k = 0; k < n; k++) begin
            d = col_major_reg ? (n - 1 - k) : k;
            off = size_of(start_reg, d) + digit[d] + size_of(full_reg, d) * off;
        end
        a.byte_offset = off * 64'(extent_reg);
        s = size_of(sub_reg, col_major_reg ? 0 : (n - 1));
        a.run_length = RUN_W'(s * 64'(extent_reg));
        a.in_range = (64'(region) < regions);
        return a;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t: %s got %h expected %h", $realtime, what, got, want);
        o_errors++;
    endtask

    always @(posedge i_clk) begin
        t_address want;
        if (!i_rst_n) begin
            dims_reg      <= 3'd1;
            col_major_reg <= 1'b0;
            extent_reg    <= 16'd1;
            full_reg      <= SIZES_RESET;
            sub_reg       <= SIZES_RESET;
            start_reg     <= '0;
            address_q.delete();
            o_errors      = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (address_q.size() == 0) begin
                    report_mismatch("unexpected transaction, offset", i_byte_offset, '0);
                end else begin
                    want = address_q.pop_front();
                    if (i_byte_offset !== want.byte_offset)
                        report_mismatch("byte_offset", i_byte_offset, want.byte_offset);
                    if (i_run_length !== want.run_length)
                        report_mismatch("run_length", 64'(i_run_length), 64'(want.run_length));
                    if (i_index_in_range !== want.in_range)
                        report_mismatch("index_in_range", 64'(i_index_in_range),
                                        64'(want.in_range));
                end
            end
            if (i_valid && !i_stall_in) address_q.push_back(region_address(i_region_index));
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_DIM_COUNT:    dims_reg      <= i_cfg_data[DCNT_W-1:0];
                    REG_COLUMN_MAJOR: col_major_reg <= i_cfg_data[0];
                    REG_ELEM_EXTENT:  extent_reg    <= i_cfg_data[EXT_W-1:0];
                    REG_FULL_SIZES:   full_reg      <= i_cfg_data;
                    REG_SUB_SIZES:    sub_reg       <= i_cfg_data;
                    REG_START_OFFS:   start_reg     <= i_cfg_data;
                    default: ;
                endcase
            end
        end
        o_pending = address_q.size();
    end

endmodule

[test/tb_top.sv]
// Testbench top: clock, reset, stimulus and verdict for the region address generator.
`timescale 1ns / 100ps

module tb_top;
    import sra_pkg::*;

    // Register slots past the last defined one; writes there must be ignored.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;
    localparam int SETTLE_CYCLES = 60;     // a little over the pipeline latency
    localparam int HOLD_CYCLES   = 300;    // long receiver hold-off, fills the block
    localparam int STUCK_LIMIT   = 5000;   // cycles without any transaction

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    logic [IDX_W-1:0]      i_region_index = '0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic [OFF_W-1:0]      o_byte_offset;
    logic [RUN_W-1:0]      o_run_length;
    logic                  o_index_in_range;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    int                    mismatches;
    int                    outstanding;
    bit                    idling_on = 1'b1;
    bit                    hold_request = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    subarray_region_address u_dut (.*);

    sra_checker u_checker (
        .i_clk, .i_rst_n, .i_valid,
        .i_stall_in      (o_stall),
        .i_region_index,
        .i_out_valid     (o_valid),
        .i_out_stall     (i_stall),
        .i_byte_offset   (o_byte_offset),
        .i_run_length    (o_run_length),
        .i_index_in_range(o_index_in_range),
        .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .o_errors        (mismatches),
        .o_pending       (outstanding)
    );

    // Receiver: random stall bursts, one long hold-off on request, none at the end.
    initial begin
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(posedge i_clk);
            end else if (idling_on && $urandom_range(0, 4) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 15) - 1) @(posedge i_clk);
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // Watchdog: end the run if nothing moves on any channel for too long.
    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall) || i_cfg_we) quiet = 0;
            else quiet++;
            if (quiet >= STUCK_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // Offer one region index and hold it until the block takes it.
    task automatic send_region(input logic [IDX_W-1:0] idx);
        if (idling_on && $urandom_range(0, 6) == 0) begin
            i_valid <= 1'b0;
            i_region_index <= IDX_W'({$urandom, $urandom});
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_region_index <= idx;
        @(posedge i_clk iff !o_stall);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    // Drain the block, then load a full register set (plus a write to a spare slot).
    task automatic reconfigure(input logic [2:0] dims, input logic col,
                               input logic [15:0] ext, input logic [63:0] full,
                               input logic [63:0] sub, input logic [63:0] start);
        i_valid <= 1'b0;
        @(posedge i_clk iff outstanding == 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        write_reg(REG_DIM_COUNT, {$urandom, 29'(0), dims});
        write_reg(REG_COLUMN_MAJOR, {$urandom, 31'(0), col});
        write_reg(REG_ELEM_EXTENT, {$urandom, 16'(0), ext});
        write_reg(REG_FULL_SIZES, full);
        write_reg(REG_SUB_SIZES, sub);
        write_reg(REG_START_OFFS, start);
        write_reg(($urandom_range(0, 1) != 0) ? REG_SPARE_A : REG_SPARE_B,
                  {$urandom, $urandom});
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [63:0] rand_sizes(input int lo, input int hi);
        logic [63:0] v;
        for (int d = 0; d < MAX_DIMS; d++) begin
            case ($urandom_range(0, 15))
                0:       v[d*16 +: 16] = 16'd0;
                1:       v[d*16 +: 16] = 16'hFFFF;
                default: v[d*16 +: 16] = 16'($urandom_range(lo, hi));
            endcase
        end
        return v;
    endfunction

    function automatic logic [IDX_W-1:0] rand_region();
        case ($urandom_range(0, 9))
            0:       return IDX_W'({$urandom, $urandom});
            1:       return '1;
            2:       return IDX_W'($urandom_range(0, 200000));
            default: return IDX_W'($urandom_range(0, 2000));
        endcase
    endfunction

    initial begin
        logic [15:0] ext;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset settings, bit patterns and index extremes.
        send_region('0);
        send_region(48'd1);
        send_region('1);
        send_region({24{2'b01}});
        send_region({24{2'b10}});

        // Everything at its top: four dims, maximum sizes, starts and extent.
        reconfigure(3'd4, 1'b0, 16'hFFFF, '1, '1, '1);
        send_region('0);
        send_region('1);
        send_region(48'hFFFD_0002_FFFE);   // last index in range
        send_region(48'hFFFD_0002_FFFF);   // first index out of range

        // Zero dim count acts as one dimension; zero extent.
        reconfigure(3'd0, 1'b1, 16'd0, 64'h0003_0004_0005_0006,
                    64'h0002_0003_0004_0005, 64'h0001_0001_0001_0001);
        send_region('0);
        send_region(48'd7);

        // Dim count above four, column-major, a zero sub size, a zero full size,
        // starts past most of the full sizes.
        reconfigure(3'd7, 1'b1, 16'd3, 64'h0009_0000_0007_0006,
                    64'h0004_0003_0000_0002, 64'hFFFF_0010_0008_0003);
        send_region('0);
        send_region(48'd5);
        send_region(48'd23);
        send_region('1);

        // Row-major, three dims, extent one.
        reconfigure(3'd3, 1'b0, 16'd1, 64'h0000_0010_000A_0008,
                    64'h0000_0004_0003_0002, 64'h0000_0002_0001_0000);
        for (int i = 0; i < 8; i++) send_region(IDX_W'(i));

        // Random settings; the long receiver hold-off lands in the third phase,
        // the last phase runs without idling.
        for (int p = 0; p < 11; p++) begin
            case ($urandom_range(0, 5))
                0:       ext = 16'd1;
                1:       ext = 16'hFFFF;
                default: ext = 16'($urandom_range(0, 65535));
            endcase
            reconfigure(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)), ext,
                        ($urandom_range(0, 2) == 0) ? {$urandom, $urandom}
                                                    : rand_sizes(1, 40),
                        rand_sizes(1, 12),
                        ($urandom_range(0, 2) == 0) ? {$urandom, $urandom}
                                                    : rand_sizes(0, 8));
            if (p == 2) hold_request = 1'b1;
            if (p == 10) idling_on = 1'b0;
            repeat (50) send_region(rand_region());
        end

        i_valid <= 1'b0;
        @(posedge i_clk iff outstanding == 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
